@@ design/khc_pkg.sv @@
// ----------------------------------------------------------------------------
// khc_pkg
// Shared types and constants for the k-mer histogram counter: command codes,
// queue operation codes, back-end state encoding and fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package khc_pkg;

   // request command codes, carried in req_tuser
   typedef enum logic [1:0] {
      CMD_BASE  = 2'd0,
      CMD_START = 2'd1,
      CMD_READ  = 2'd2,
      CMD_CLEAR = 2'd3
   } cmd_type;

   // operations handed from the front end to the back end
   typedef enum logic [1:0] {
      OP_NONE  = 2'd0,
      OP_COUNT = 2'd1,
      OP_READ  = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   // back-end states: clearing sweep over the histogram, or normal run
   typedef enum logic {
      ST_SWEEP = 1'b0,
      ST_RUN   = 1'b1
   } back_state_type;

   localparam int unsigned OP_WIDTH    = 2;
   localparam int unsigned BASE_WIDTH  = 2;
   localparam int unsigned QUERY_WIDTH = 16;
   localparam int unsigned INDEX_WIDTH = 16;
   localparam int unsigned VALUE_WIDTH = 32;
   localparam int unsigned KLEN_WIDTH  = 4;
   localparam int unsigned QUEUE_DEPTH = 4;

   localparam logic [KLEN_WIDTH-1:0] WORD_LENGTH_RESET = 4'd8;
   localparam logic [KLEN_WIDTH-1:0] SEEN_MAX          = 4'd15;

endpackage

`default_nettype wire

@@ design/khc_ram.sv @@
// ----------------------------------------------------------------------------
// khc_ram
// Generic single-write, single-read RAM with registered read data.
// A read and a write to the same address in one cycle return the old data.
// ----------------------------------------------------------------------------
`default_nettype none

module khc_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 65536
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ design/khc_fifo.sv @@
// ----------------------------------------------------------------------------
// khc_fifo
// Short register queue between the front end and the back end.
// Head entry is shown combinationally while the queue is not empty.
// ----------------------------------------------------------------------------
`default_nettype none

module khc_fifo #(
   parameter int unsigned WIDTH = 18,
   parameter int unsigned DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] pop_data,
   output logic                  not_empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wptr_ff, wptr_in;
   logic [PTR_W-1:0] rptr_ff, rptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = slot_ff[rptr_ff];

   // pointer and fill count update
   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (push) begin
         wptr_in = (wptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (pop) begin
         rptr_in = (rptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

@@ design/khc_front.sv @@
// ----------------------------------------------------------------------------
// khc_front
// Front end: takes requests and the word length register, keeps the sliding
// base window and the per-sequence base count, and turns each request into
// one queue operation (count, read, clear or none).
// ----------------------------------------------------------------------------
`default_nettype none

module khc_front #(
   parameter int unsigned MAX_WORD_LENGTH = 8
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   // request channel
   input  wire logic                                      req_tvalid,
   output logic                                           req_tready,
   input  wire logic [1:0]                                req_tuser,
   input  wire logic [23:0]                               req_tdata,
   // word length register
   input  wire logic                                      csr_valid,
   input  wire logic [khc_pkg::KLEN_WIDTH-1:0]            csr_data,
   // queue side
   input  wire logic                                      q_full,
   input  wire logic                                      sweeping,
   output logic                                           push,
   output logic [khc_pkg::OP_WIDTH+2*MAX_WORD_LENGTH-1:0] push_entry
);

   localparam int unsigned ADDR_W = 2 * MAX_WORD_LENGTH;

   logic [khc_pkg::KLEN_WIDTH-1:0]  word_length_ff, word_length_in;
   logic [khc_pkg::KLEN_WIDTH-1:0]  seen_ff, seen_in, seen_step, k_eff;
   logic [ADDR_W-1:0]               window_ff, window_in, window_shift, window_step;
   logic [ADDR_W-1:0]               query_addr, push_addr;
   logic [khc_pkg::BASE_WIDTH-1:0]  base;
   logic [khc_pkg::QUERY_WIDTH-1:0] query;
   khc_pkg::cmd_type                cmd;
   khc_pkg::op_type                 push_op;
   logic                            accept;

   assign req_tready = !q_full && !sweeping;
   assign accept     = req_tvalid && req_tready;
   assign cmd        = khc_pkg::cmd_type'(req_tuser);
   assign base       = req_tdata[1:0];
   assign query      = req_tdata[17:2];

   // read address: query masked or widened to the table address
   generate
      if (ADDR_W <= khc_pkg::QUERY_WIDTH) begin : g_query_cut
         assign query_addr = query[ADDR_W-1:0];
      end else begin : g_query_ext
         assign query_addr = {{(ADDR_W - khc_pkg::QUERY_WIDTH){1'b0}}, query};
      end
   endgenerate

   // effective k: zero reads as one, too large reads as the maximum
   always_comb begin
      if (word_length_ff == '0) begin
         k_eff = khc_pkg::KLEN_WIDTH'(1);
      end else if (word_length_ff > khc_pkg::KLEN_WIDTH'(MAX_WORD_LENGTH)) begin
         k_eff = khc_pkg::KLEN_WIDTH'(MAX_WORD_LENGTH);
      end else begin
         k_eff = word_length_ff;
      end
   end

   // window shift: oldest base drops, new base enters at position k-1
   assign window_shift = window_ff >> 2;
   always_comb begin
      for (int p = 0; p < MAX_WORD_LENGTH; p++) begin
         if (khc_pkg::KLEN_WIDTH'(p) + 1'b1 < k_eff) begin
            window_step[2*p +: 2] = window_shift[2*p +: 2];
         end else if (khc_pkg::KLEN_WIDTH'(p) + 1'b1 == k_eff) begin
            window_step[2*p +: 2] = base;
         end else begin
            window_step[2*p +: 2] = 2'b00;
         end
      end
   end

   // saturating base count for the current sequence
   assign seen_step = (seen_ff == khc_pkg::SEEN_MAX) ? seen_ff : seen_ff + 1'b1;

   // request decode and state next values
   always_comb begin
      word_length_in = word_length_ff;
      window_in      = window_ff;
      seen_in        = seen_ff;
      push_op        = khc_pkg::OP_NONE;
      push_addr      = '0;
      if (accept) begin
         case (cmd)
            khc_pkg::CMD_BASE: begin
               window_in = window_step;
               seen_in   = seen_step;
               if (seen_step >= k_eff) begin
                  push_op   = khc_pkg::OP_COUNT;
                  push_addr = window_step;
               end
            end
            khc_pkg::CMD_START: begin
               window_in = '0;
               seen_in   = '0;
            end
            khc_pkg::CMD_READ: begin
               push_op   = khc_pkg::OP_READ;
               push_addr = query_addr;
            end
            khc_pkg::CMD_CLEAR: begin
               push_op = khc_pkg::OP_CLEAR;
            end
            default: begin
               push_op = khc_pkg::OP_NONE;
            end
         endcase
      end
      // a word length write also starts a new sequence
      if (csr_valid) begin
         word_length_in = csr_data;
         window_in      = '0;
         seen_in        = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_length_ff <= khc_pkg::WORD_LENGTH_RESET;
         window_ff      <= '0;
         seen_ff        <= '0;
      end else begin
         word_length_ff <= word_length_in;
         window_ff      <= window_in;
         seen_ff        <= seen_in;
      end
   end

   assign push       = accept;
   assign push_entry = {push_op, push_addr};

endmodule

`default_nettype wire

@@ design/khc_back.sv @@
// ----------------------------------------------------------------------------
// khc_back
// Back end: runs queue operations against the histogram RAM. Two stages:
// the RAM read is issued on pop, the counter update and write happen when
// the operation leaves the execute stage. A last-write register forwards
// the newest value of an address even when it was written as its read was issued.
// Also sweeps the RAM to zero after reset and on a clear operation.
// ----------------------------------------------------------------------------
`default_nettype none

module khc_back #(
   parameter int unsigned MAX_WORD_LENGTH = 8,
   parameter int unsigned COUNT_WIDTH     = 32
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   // queue side
   input  wire logic                                      q_valid,
   input  wire logic [khc_pkg::OP_WIDTH+2*MAX_WORD_LENGTH-1:0] q_entry,
   output logic                                           q_pop,
   output logic                                           sweeping,
   // result channel
   output logic                                           rsp_tvalid,
   input  wire logic                                      rsp_tready,
   output logic                                           rsp_tuser,
   output logic [47:0]                                    rsp_tdata
);

   localparam int unsigned ADDR_W = 2 * MAX_WORD_LENGTH;
   localparam int unsigned DEPTH  = 2 ** ADDR_W;

   khc_pkg::back_state_type state_ff, state_in;
   logic [ADDR_W-1:0]       sweep_ff, sweep_in;

   khc_pkg::op_type         head_op;
   logic [ADDR_W-1:0]       head_addr;

   logic                    b_valid_ff, b_valid_in;
   khc_pkg::op_type         b_op_ff;
   logic [ADDR_W-1:0]       b_addr_ff;
   logic                    b_fire;

   logic                    fwd_valid_ff;
   logic [ADDR_W-1:0]       fwd_addr_ff;
   logic [COUNT_WIDTH-1:0]  fwd_data_ff;

   logic                    ram_we;
   logic [ADDR_W-1:0]       ram_waddr;
   logic [COUNT_WIDTH-1:0]  ram_wdata, ram_rdata;
   logic [COUNT_WIDTH-1:0]  cur_value, inc_value;

   logic [khc_pkg::INDEX_WIDTH-1:0] b_index;
   logic [khc_pkg::VALUE_WIDTH-1:0] b_value;

   logic                            out_valid_ff, out_valid_in;
   logic                            out_counted_ff;
   logic [khc_pkg::INDEX_WIDTH-1:0] out_index_ff;
   logic [khc_pkg::VALUE_WIDTH-1:0] out_value_ff;

   assign head_op   = khc_pkg::op_type'(q_entry[ADDR_W +: khc_pkg::OP_WIDTH]);
   assign head_addr = q_entry[ADDR_W-1:0];
   assign sweeping  = (state_ff == khc_pkg::ST_SWEEP);

   // execute stage leaves when the output register can take its result
   assign b_fire = b_valid_ff && (!out_valid_ff || rsp_tready);

   // pop into execute; nothing follows a clear until its sweep is done
   assign q_pop = (state_ff == khc_pkg::ST_RUN) && q_valid
                  && (!b_valid_ff || b_fire)
                  && !(b_valid_ff && (b_op_ff == khc_pkg::OP_CLEAR));

   // histogram memory
   khc_ram #(
      .WIDTH (COUNT_WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (q_pop),
      .rd_addr (head_addr),
      .rd_data (ram_rdata)
   );

   // current counter value with forwarding of the newest write
   assign cur_value = (fwd_valid_ff && (fwd_addr_ff == b_addr_ff)) ? fwd_data_ff : ram_rdata;
   assign inc_value = (cur_value == {COUNT_WIDTH{1'b1}}) ? cur_value : cur_value + 1'b1;

   // counted index, base-4 packed window cut or widened to 16 bits
   generate
      if (ADDR_W >= khc_pkg::INDEX_WIDTH) begin : g_index_cut
         assign b_index = b_addr_ff[khc_pkg::INDEX_WIDTH-1:0];
      end else begin : g_index_ext
         assign b_index = {{(khc_pkg::INDEX_WIDTH - ADDR_W){1'b0}}, b_addr_ff};
      end
   endgenerate

   // reported counter value, saturated or zero-widened to 32 bits
   generate
      if (COUNT_WIDTH > khc_pkg::VALUE_WIDTH) begin : g_value_sat
         assign b_value = (cur_value[COUNT_WIDTH-1:khc_pkg::VALUE_WIDTH] != '0)
                          ? {khc_pkg::VALUE_WIDTH{1'b1}}
                          : cur_value[khc_pkg::VALUE_WIDTH-1:0];
      end else if (COUNT_WIDTH == khc_pkg::VALUE_WIDTH) begin : g_value_eq
         assign b_value = cur_value;
      end else begin : g_value_ext
         assign b_value = {{(khc_pkg::VALUE_WIDTH - COUNT_WIDTH){1'b0}}, cur_value};
      end
   endgenerate

   // sweep and run control, RAM write port
   always_comb begin
      state_in  = state_ff;
      sweep_in  = sweep_ff;
      ram_we    = 1'b0;
      ram_waddr = b_addr_ff;
      ram_wdata = inc_value;
      case (state_ff)
         khc_pkg::ST_SWEEP: begin
            ram_we    = 1'b1;
            ram_waddr = sweep_ff;
            ram_wdata = '0;
            sweep_in  = sweep_ff + 1'b1;
            if (sweep_ff == {ADDR_W{1'b1}}) begin
               state_in = khc_pkg::ST_RUN;
            end
         end
         khc_pkg::ST_RUN: begin
            if (b_fire && (b_op_ff == khc_pkg::OP_COUNT)) begin
               ram_we = 1'b1;
            end
            if (b_fire && (b_op_ff == khc_pkg::OP_CLEAR)) begin
               state_in = khc_pkg::ST_SWEEP;
            end
         end
         default: begin
            state_in = khc_pkg::ST_SWEEP;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= khc_pkg::ST_SWEEP;
         sweep_ff <= '0;
      end else begin
         state_ff <= state_in;
         sweep_ff <= sweep_in;
      end
   end

   // execute stage
   always_comb begin
      b_valid_in = b_valid_ff;
      if (q_pop) begin
         b_valid_in = 1'b1;
      end else if (b_fire) begin
         b_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         b_op_ff   <= head_op;
         b_addr_ff <= head_addr;
      end
   end

   // last write, always the newest value of its address
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else if (ram_we) begin
         fwd_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ram_we) begin
         fwd_addr_ff <= ram_waddr;
         fwd_data_ff <= ram_wdata;
      end
   end

   // output register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (b_fire) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (b_fire) begin
         out_counted_ff <= (b_op_ff == khc_pkg::OP_COUNT);
         out_index_ff   <= (b_op_ff == khc_pkg::OP_COUNT) ? b_index : '0;
         out_value_ff   <= (b_op_ff == khc_pkg::OP_READ) ? b_value : '0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_counted_ff;
   assign rsp_tdata  = {out_value_ff, out_index_ff};

endmodule

`default_nettype wire

@@ design/kmer_histogram_counter.sv @@
// ----------------------------------------------------------------------------
// kmer_histogram_counter
// Counts overlapping k-mers of DNA sequences streamed one base per request
// into a saturating histogram of 4^MAX_WORD_LENGTH counters.
// ----------------------------------------------------------------------------
//  channel  dir  handshake               payload
//  req_     in   req_tvalid/req_tready   tuser: cmd; tdata: base, query_index
//  rsp_     out  rsp_tvalid/rsp_tready   tuser: counted; tdata: index, value
//  csr_     in   csr_valid/csr_ready     csr_data: word_length
//
//  One request per cycle while no sweep runs and no response stalls, one
//  response per request, in order; each request passes through the queue,
//  the execute stage and the output register before its response is valid.
//  The counter read-modify-write spans the RAM read and the execute stage;
//  the last-write forwarding register keeps back-to-back hits on one counter
//  at full rate. After reset, and after each clear command, the histogram
//  RAM is swept to zero; req_tready is low meanwhile. A stalled response
//  holds the back end, then the queue, then req_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module kmer_histogram_counter #(
   parameter int unsigned MAX_WORD_LENGTH = 8,
   parameter int unsigned COUNT_WIDTH     = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [1:0]  req_tuser,   // [1:0] cmd
   input  wire logic [23:0] req_tdata,   // [1:0] base, [17:2] query_index, [23:18] zero
   // response channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic             rsp_tuser,   // [0] counted
   output logic [47:0]      rsp_tdata,   // [15:0] counted_index, [47:16] count_value
   // word length register
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [3:0]  csr_data     // [3:0] word_length
);

   localparam int unsigned ENTRY_W = khc_pkg::OP_WIDTH + 2 * MAX_WORD_LENGTH;

   logic               push, pop, q_full, q_valid, sweeping;
   logic [ENTRY_W-1:0] push_entry, head_entry;

   // register writes are taken at any time
   assign csr_ready = 1'b1;

   // front end: window, base count and request decode
   khc_front #(
      .MAX_WORD_LENGTH (MAX_WORD_LENGTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .q_full     (q_full),
      .sweeping   (sweeping),
      .push       (push),
      .push_entry (push_entry)
   );

   // operation queue
   khc_fifo #(
      .WIDTH (ENTRY_W),
      .DEPTH (khc_pkg::QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_entry),
      .full      (q_full),
      .pop       (pop),
      .pop_data  (head_entry),
      .not_empty (q_valid)
   );

   // back end: histogram RAM, counter update, response register
   khc_back #(
      .MAX_WORD_LENGTH (MAX_WORD_LENGTH),
      .COUNT_WIDTH     (COUNT_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_entry    (head_entry),
      .q_pop      (pop),
      .sweeping   (sweeping),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

@@ design/khc_checker.sv @@
// ----------------------------------------------------------------------------
// khc_checker
// Port-level checks for the k-mer histogram counter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module khc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic        rsp_tuser,
   input wire logic [47:0] rsp_tdata
);

   // stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // no index without a counted k-mer
   a_index_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[15:0] == 16'd0)
      else $error("counted_index set on a response that counted nothing");

   // a counted base never carries a read value
   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[47:16] == 32'd0)
      else $error("count_value set on a counted base");

   // clearing sweep holds off requests right after reset
   a_sweep_after_reset: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("request taken before the histogram sweep");

   // nothing shown right after reset
   a_rsp_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

endmodule

bind kmer_histogram_counter khc_checker u_khc_checker (.*);

`default_nettype wire
